FILE: rtl/dpud_pkg.sv
// ----------------------------------------------------------------------------
// dpud_pkg
// Shared types and constants of the dirty pixel upscale drawer.
// ----------------------------------------------------------------------------
package dpud_pkg;

   // Item kinds carried on req_tuser
   localparam logic [1:0] MODE_PALETTE = 2'd0;
   localparam logic [1:0] MODE_PIXEL   = 2'd1;
   localparam logic [1:0] MODE_CANCEL  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

   localparam int SCREEN_W = 11;
   localparam int IMAGE_W  = 9;

   localparam logic [SCREEN_W-1:0] SCREEN_RESET = 11'd240;
   localparam logic [IMAGE_W-1:0]  IMAGE_RESET  = 9'd240;

   localparam logic [15:0] CANVAS_CLEAR = 16'd100;

   // Stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   // Shared divider: 9-bit coordinate times 11-bit screen size, over a 9-bit image size
   localparam int DVD_W      = 20;
   localparam int DIV_STEP_W = 5;
   localparam int QUO_W      = 11;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_width;
      logic [SCREEN_W-1:0] screen_height;
      logic [IMAGE_W-1:0]  image_width;
      logic [IMAGE_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] color;
      logic [9:0]  frame_top;
      logic [7:0]  row;
      logic [7:0]  column;
   } job_type;

   typedef struct packed {
      logic clearing;
      logic cancel_pending;
   } front_stat_type;

endpackage

FILE: rtl/dpud_ram.sv
// ----------------------------------------------------------------------------
// dpud_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dpud_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dpud_front.sv
// ----------------------------------------------------------------------------
// dpud_front
// Accepts items, keeps the palette, the canvas cache and the cancel flag, and
// queues one job for every pixel whose color changed.
// ----------------------------------------------------------------------------
module dpud_front #(
   parameter int MAX_IMAGE_WIDTH  = 256,
   parameter int MAX_IMAGE_HEIGHT = 256,
   parameter int PALETTE_DEPTH    = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear_start,
   input  dpud_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               mode,
   input  logic [7:0]               column,
   input  logic [7:0]               row,
   input  logic [7:0]               pixel_index,
   input  logic [15:0]              palette_color,
   input  logic [9:0]               frame_top,
   input  logic                     queue_full,
   output logic                     queue_push,
   output dpud_pkg::job_type        queue_job,
   output dpud_pkg::front_stat_type stat
);

   import dpud_pkg::*;

   localparam int CANVAS_DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
   localparam int CAW = (CANVAS_DEPTH > 1) ? $clog2(CANVAS_DEPTH) : 1;
   localparam int PAW = $clog2(PALETTE_DEPTH);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [CAW-1:0] clr_addr_ff, clr_addr_in;
   logic           cancel_ff, cancel_in;
   job_type        job_ff, job_in;
   logic           pidx_ok_ff, pidx_ok_in;
   logic [CAW-1:0] canvas_addr_ff, canvas_addr_in;

   logic [10:0]    ew, eh;
   logic           in_range, pidx_ok, last_pixel, accept, changed;
   logic [CAW-1:0] canvas_addr;
   logic [15:0]    pal_rdata, canvas_rdata, pal_color;
   logic           canvas_wr_en, pal_wr_en;
   logic [CAW-1:0] canvas_wr_addr;
   logic [15:0]    canvas_wr_data;

   always_comb begin
      ew = ({2'b0, cfg.image_width} < 11'(MAX_IMAGE_WIDTH)) ?
           {2'b0, cfg.image_width} : 11'(MAX_IMAGE_WIDTH);
      eh = ({2'b0, cfg.image_height} < 11'(MAX_IMAGE_HEIGHT)) ?
           {2'b0, cfg.image_height} : 11'(MAX_IMAGE_HEIGHT);
      in_range    = ({3'b0, column} < ew) && ({3'b0, row} < eh);
      pidx_ok     = {1'b0, pixel_index} < 9'(PALETTE_DEPTH);
      canvas_addr = CAW'(CAW'(row) * CAW'(ew) + CAW'(column));
      last_pixel  = (({1'b0, column} + 9'd1) == cfg.image_width) &&
                    (({1'b0, row} + 9'd1) == cfg.image_height);

      req_ready = (state_ff == ST_ACCEPT) && !queue_full;
      accept    = req_valid && req_ready;

      // out-of-range palette index reads as black
      pal_color = pidx_ok_ff ? pal_rdata : 16'd0;
      changed   = (state_ff == ST_LOOKUP) && (canvas_rdata != pal_color);

      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cancel_in      = cancel_ff;
      job_in         = job_ff;
      pidx_ok_in     = pidx_ok_ff;
      canvas_addr_in = canvas_addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + CAW'(1);
            if (clr_addr_ff == CAW'(CANVAS_DEPTH - 1)) begin
               state_in = ST_ACCEPT;
            end
         end
         ST_ACCEPT: begin
            if (accept) begin
               case (mode)
                  MODE_CANCEL: begin
                     cancel_in = 1'b1;
                  end
                  MODE_PIXEL: begin
                     if (cancel_ff) begin
                        // drop pixels until the last one of the frame
                        if (last_pixel) begin
                           cancel_in = 1'b0;
                        end
                     end else if (in_range) begin
                        state_in         = ST_LOOKUP;
                        job_in.column    = column;
                        job_in.row       = row;
                        job_in.frame_top = frame_top;
                        job_in.color     = 16'd0;
                        pidx_ok_in       = pidx_ok;
                        canvas_addr_in   = canvas_addr;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            state_in = ST_ACCEPT;
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase

      if (clear_start) begin
         state_in    = ST_CLEAR;
         clr_addr_in = '0;
      end

      canvas_wr_en   = (state_ff == ST_CLEAR) || changed;
      canvas_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : canvas_addr_ff;
      canvas_wr_data = (state_ff == ST_CLEAR) ? CANVAS_CLEAR : pal_color;
      pal_wr_en      = accept && (mode == MODE_PALETTE) && pidx_ok;

      queue_push          = changed;
      queue_job.column    = job_ff.column;
      queue_job.row       = job_ff.row;
      queue_job.frame_top = job_ff.frame_top;
      queue_job.color     = pal_color;

      stat.clearing       = (state_ff == ST_CLEAR);
      stat.cancel_pending = cancel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         cancel_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cancel_ff   <= cancel_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      pidx_ok_ff     <= pidx_ok_in;
      canvas_addr_ff <= canvas_addr_in;
   end

   dpud_ram #(
      .WIDTH (16),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pixel_index[PAW-1:0]),
      .wr_data (palette_color),
      .rd_addr (pixel_index[PAW-1:0]),
      .rd_data (pal_rdata)
   );

   dpud_ram #(
      .WIDTH (16),
      .DEPTH (CANVAS_DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (canvas_wr_en),
      .wr_addr (canvas_wr_addr),
      .wr_data (canvas_wr_data),
      .rd_addr (canvas_addr),
      .rd_data (canvas_rdata)
   );

endmodule

FILE: rtl/dpud_queue.sv
// ----------------------------------------------------------------------------
// dpud_queue
// Short job FIFO between the front and the rectangle back end.
// ----------------------------------------------------------------------------
module dpud_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dpud_pkg::job_type push_job,
   input  logic              pop,
   output dpud_pkg::job_type pop_job,
   output logic              not_empty,
   output logic              full
);

   import dpud_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job   = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/dpud_back.sv
// ----------------------------------------------------------------------------
// dpud_back
// Turns a queued job into a fill rectangle: four scaled starts on one shared
// restoring divider, then an output register toward the result stream.
// ----------------------------------------------------------------------------
module dpud_back (
   input  logic                                clock,
   input  logic                                reset,
   input  dpud_pkg::cfg_type                   cfg,
   input  logic                                queue_valid,
   input  dpud_pkg::job_type                   queue_job,
   output logic                                queue_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dpud_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import dpud_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // quotient order: left start, right start, top start, bottom start
   localparam logic [1:0] SEL_LAST = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            sel_ff, sel_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   job_type               job_ff, job_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [IMAGE_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff [4];
   logic [QUO_W-1:0]      quo_in [4];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [8:0]            operand;
   logic [SCREEN_W-1:0]   scale;
   logic [IMAGE_W-1:0]    divisor;
   logic [IMAGE_W:0]      trial;
   logic                  fits;
   logic [DVD_W-1:0]      quotient;
   logic                  out_free;

   always_comb begin
      operand  = {1'b0, (sel_ff[1] ? job_ff.row : job_ff.column)} + {8'd0, sel_ff[0]};
      scale    = sel_ff[1] ? cfg.screen_height : cfg.screen_width;
      divisor  = sel_ff[1] ? cfg.image_height : cfg.image_width;
      trial    = {rem_ff, dvd_ff[DVD_W-1]};
      fits     = trial >= {1'b0, divisor};
      quotient = {dvd_ff[DVD_W-2:0], fits};
      out_free = !rsp_valid_ff || rsp_tready;

      state_in     = state_ff;
      sel_in       = sel_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      queue_pop    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               job_in    = queue_job;
               sel_in    = 2'd0;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dvd_in   = DVD_W'(operand) * DVD_W'(scale);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? IMAGE_W'(trial - {1'b0, divisor}) : trial[IMAGE_W-1:0];
            dvd_in  = quotient;
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(DVD_W - 1)) begin
               quo_in[sel_ff] = quotient[QUO_W-1:0];
               if (sel_ff == SEL_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0,
                               job_ff.color,
                               QUO_W'(quo_ff[3] - quo_ff[2]),
                               QUO_W'(quo_ff[1] - quo_ff[0]),
                               QUO_W'({1'b0, job_ff.frame_top} + quo_ff[2]),
                               quo_ff[0][9:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      step_ff     <= step_in;
      job_ff      <= job_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/dirty_pixel_upscale_drawer.sv
// Palette-indexed image drawer with dirty-pixel skipping and nearest-neighbor
// upscaling. Palette writes, cancels and pixels that are dropped (cancelled
// frame, outside the image) leave the front end in its accepting state; a
// pixel that reaches the canvas cache holds the front end for its palette and
// canvas reads. Each changed pixel then needs four 20-step quotients in the
// back end, computed one bit per cycle on a single shared divider; a
// four-entry job queue lets the front keep accepting meanwhile. After reset
// and after every write of image_width or image_height, the canvas cache is
// cleared over all MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT entries (65536 by
// default), during which no item is accepted; configuration writes are taken
// at any time.
// ----------------------------------------------------------------------------
// dirty_pixel_upscale_drawer
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
module dirty_pixel_upscale_drawer #(
   parameter int MAX_IMAGE_WIDTH  = 256,
   parameter int MAX_IMAGE_HEIGHT = 256,
   parameter int PALETTE_DEPTH    = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   // column[7:0], row[15:8], pixel_index[23:16], palette_color[39:24],
   // frame_top[49:40], zero fill above
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dpud_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]                      req_tuser,
   // rect_x[9:0], rect_y[20:10], rect_width[31:21], rect_height[42:32],
   // fill_color[58:43], zero fill above
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dpud_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [1:0]                      csr_index,
   input  logic [10:0]                     csr_wdata
);

   import dpud_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           clear_start;
   logic           queue_push, queue_pop, queue_valid, queue_full;
   job_type        push_job, pop_job;
   front_stat_type front_stat;

   always_comb begin
      cfg_in      = cfg_ff;
      clear_start = 1'b0;
      if (csr_wen) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata;
            REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata[IMAGE_W-1:0];
               clear_start        = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata[IMAGE_W-1:0];
               clear_start         = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_RESET;
         cfg_ff.screen_height <= SCREEN_RESET;
         cfg_ff.image_width   <= IMAGE_RESET;
         cfg_ff.image_height  <= IMAGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpud_front #(
      .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
      .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
      .PALETTE_DEPTH    (PALETTE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .clear_start   (clear_start),
      .cfg           (cfg_ff),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .mode          (req_tuser),
      .column        (req_tdata[7:0]),
      .row           (req_tdata[15:8]),
      .pixel_index   (req_tdata[23:16]),
      .palette_color (req_tdata[39:24]),
      .frame_top     (req_tdata[49:40]),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_job     (push_job),
      .stat          (front_stat)
   );

   dpud_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_job  (push_job),
      .pop       (queue_pop),
      .pop_job   (pop_job),
      .not_empty (queue_valid),
      .full      (queue_full)
   );

   dpud_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_job   (pop_job),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      front_stat.clearing |-> !req_tready)
      else $error("item accepted during canvas clear");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_full)
      else $error("job pushed into a full queue");

   a_size_write_clears : assert property (@(posedge clock) disable iff (reset)
      (csr_wen && (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT))
      |=> front_stat.clearing)
      else $error("image size write did not start a canvas clear");

   a_cancel_sets_flag : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_CANCEL) |=> front_stat.cancel_pending)
      else $error("cancel item did not set the cancel flag");

endmodule

FILE: dv/dirty_pixel_upscale_drawer_tb.sv
// ----------------------------------------------------------------------------
// dirty_pixel_upscale_drawer_tb
// Self-checking bench for the palette drawer. It streams palette loads, pixel
// draws and frame cancels through several screen and image sizes, predicts
// each fill rectangle from its own palette, canvas cache and cancel flag, and
// checks every rectangle in arrival order while both sides stall at random.
// ----------------------------------------------------------------------------
module dirty_pixel_upscale_drawer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpud_pkg::*;

   localparam int CANVAS_SIZE = 65536;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLDOFF_CYCLES = 1500;
   localparam int MAX_REPORTS = 10;

   // mode code the block ignores
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  frame_top;
      logic [15:0] palette_color;
      logic [7:0]  pixel_index;
      logic [7:0]  row;
      logic [7:0]  column;
   } draw_item_type;

   typedef struct packed {
      logic [15:0] color;
      logic [10:0] height;
      logic [10:0] width;
      logic [10:0] y;
      logic [9:0]  x;
   } fill_rect_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = MODE_PALETTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [1:0]            csr_index = REG_SCREEN_WIDTH;
   logic [10:0]           csr_wdata = '0;

   dirty_pixel_upscale_drawer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // drawer state as the bench sees it
   logic [15:0] canvas_shadow [0:CANVAS_SIZE-1];
   logic [15:0] palette_shadow [0:255];
   bit          frame_cancelled;
   int          scr_w, scr_h, img_w, img_h;

   // stimulus side
   draw_item_type draw_items_pending [$];
   draw_item_type next_item;
   fill_rect_type fill_rects_due [$];
   int            palette_loaded [$];
   bit            palette_seen [0:255];
   bit            gen_cancelled;

   int          items_offered = 0;
   int          items_accepted = 0;
   int          rects_received = 0;
   int          mismatch_count = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void clear_canvas();
      for (int i = 0; i < CANVAS_SIZE; i++) canvas_shadow[i] = CANVAS_CLEAR;
   endfunction

   function automatic int scaled_start(int i, int screen, int image);
      return (i * screen) / image;
   endfunction

   // Work out the rectangle a drawn pixel causes, if any, and update state.
   function automatic void compute_fill_rect(draw_item_type it);
      int            ew, eh, canvas_addr, x0, x1, y0, y1, col, row;
      logic [15:0]   c;
      fill_rect_type r;
      col = int'(it.column);
      row = int'(it.row);
      case (it.mode)
         MODE_PALETTE: palette_shadow[it.pixel_index] = it.palette_color;
         MODE_CANCEL:  frame_cancelled = 1'b1;
         MODE_PIXEL: begin
            if (frame_cancelled) begin
               if (col + 1 == img_w && row + 1 == img_h) frame_cancelled = 1'b0;
               return;
            end
            ew = img_w < 256 ? img_w : 256;
            eh = img_h < 256 ? img_h : 256;
            if (col >= ew || row >= eh) return;
            c = palette_shadow[it.pixel_index];
            canvas_addr = row * ew + col;
            if (canvas_addr >= CANVAS_SIZE || canvas_shadow[canvas_addr] == c) return;
            canvas_shadow[canvas_addr] = c;
            x0 = scaled_start(col, scr_w, img_w);
            x1 = scaled_start(col + 1, scr_w, img_w);
            y0 = scaled_start(row, scr_h, img_h);
            y1 = scaled_start(row + 1, scr_h, img_h);
            r.x = x0[9:0];
            r.y = 11'(int'(it.frame_top) + y0);
            r.width = 11'(x1 - x0);
            r.height = 11'(y1 - y0);
            r.color = c;
            fill_rects_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_fill_rect(fill_rect_type got);
      fill_rect_type want;
      if (fill_rects_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected rect x=%0d y=%0d w=%0d h=%0d c=%h",
                     got.x, got.y, got.width, got.height, got.color);
         return;
      end
      want = fill_rects_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.width !== want.width ||
          got.height !== want.height || got.color !== want.color) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("rect %0d: expected x=%0d y=%0d w=%0d h=%0d c=%h, got x=%0d y=%0d w=%0d h=%0d c=%h",
                     rects_received, want.x, want.y, want.width, want.height, want.color,
                     got.x, got.y, got.width, got.height, got.color);
      end
   endfunction

   // Queue an item and track what the generator needs: loaded entries, cancel.
   function automatic void queue_item(logic [1:0] mode, int col, int row, int idx,
                                      int color, int top);
      draw_item_type it;
      it.mode = mode;
      it.column = 8'(col);
      it.row = 8'(row);
      it.pixel_index = 8'(idx);
      it.palette_color = 16'(color);
      it.frame_top = 10'(top);
      if (mode == MODE_PALETTE && !palette_seen[it.pixel_index]) begin
         palette_seen[it.pixel_index] = 1'b1;
         palette_loaded.push_back(int'(it.pixel_index));
      end
      if (mode == MODE_CANCEL) gen_cancelled = 1'b1;
      if (mode == MODE_PIXEL && col + 1 == img_w && row + 1 == img_h) gen_cancelled = 1'b0;
      draw_items_pending.push_back(it);
   endfunction

   function automatic int any_loaded_index();
      return palette_loaded[$urandom_range(palette_loaded.size() - 1)];
   endfunction

   function automatic void queue_random(int count, bit allow_cancel);
      int n, r, col, row, ew, eh, idx;
      n = 0;
      ew = img_w < 256 ? img_w : 256;
      eh = img_h < 256 ? img_h : 256;
      idx = any_loaded_index();
      while (n < count) begin
         r = $urandom_range(99);
         if (r < 15) begin
            queue_item(MODE_PALETTE, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), $urandom_range(65535), $urandom_range(1023));
            n++;
         end else if (r < 18 && allow_cancel) begin
            queue_item(MODE_CANCEL, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), $urandom_range(65535), $urandom_range(1023));
            n++;
         end else if (r < 20) begin
            // unused mode, ignored by the block
            queue_item(MODE_UNUSED, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), $urandom_range(65535), $urandom_range(1023));
         end else begin
            if (gen_cancelled && $urandom_range(99) < 30) begin
               col = img_w - 1;
               row = img_h - 1;
            end else if (ew > 0 && eh > 0 && $urandom_range(99) < 85) begin
               col = $urandom_range(ew - 1);
               row = $urandom_range(eh - 1);
            end else begin
               col = $urandom_range(255);
               row = $urandom_range(255);
            end
            // reuse the last index now and then so unchanged pixels show up
            if ($urandom_range(99) >= 20) idx = any_loaded_index();
            queue_item(MODE_PIXEL, col, row, idx, $urandom_range(65535),
                       $urandom_range(1023));
            n++;
         end
      end
      // close an open cancel so the next setting starts clean
      if (gen_cancelled && img_w >= 1 && img_w <= 256 && img_h >= 1 && img_h <= 256)
         queue_item(MODE_PIXEL, img_w - 1, img_h - 1, any_loaded_index(), 0, 0);
   endfunction

   task automatic write_reg(logic [1:0] index, logic [10:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_SCREEN_WIDTH:  scr_w = int'(value);
         REG_SCREEN_HEIGHT: scr_h = int'(value);
         REG_IMAGE_WIDTH: begin
            img_w = int'(value[8:0]);
            clear_canvas();
         end
         default: begin
            img_h = int'(value[8:0]);
            clear_canvas();
         end
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic wait_idle();
      while (!(draw_items_pending.size() == 0 && items_offered == items_accepted &&
               fill_rects_due.size() == 0))
         @(negedge clock);
      // let dropped items finish in the front end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_setting(int sw, int sh, int iw, int ih, bit new_image,
                              int count, bit allow_cancel);
      write_reg(REG_SCREEN_WIDTH, 11'(sw));
      write_reg(REG_SCREEN_HEIGHT, 11'(sh));
      if (new_image) begin
         write_reg(REG_IMAGE_WIDTH, 11'(iw));
         write_reg(REG_IMAGE_HEIGHT, 11'(ih));
      end
      queue_random(count, allow_cancel);
      wait_idle();
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && items_offered != items_accepted) begin
         // hold until taken
      end else if (draw_items_pending.size() != 0 &&
                   ((items_accepted >= 500 && items_accepted < 800) ||
                    $urandom_range(99) >= 35)) begin
         next_item = draw_items_pending.pop_front();
         req_tdata <= {{(REQ_DATA_W-50){1'b0}}, next_item.frame_top, next_item.palette_color,
                       next_item.pixel_index, next_item.row, next_item.column};
         req_tuser <= next_item.mode;
         req_tvalid <= 1'b1;
         items_offered++;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // long receiver hold-off once the stream is going
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left--;
      end else if (!holdoff_done && items_offered >= 60) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_done = 1'b1;
      end
   end

   // receiver
   always @(negedge clock) begin
      rsp_tready <= !reset && holdoff_left == 0 &&
                    ((rects_received >= 150 && rects_received < 300) ||
                     $urandom_range(99) >= 35);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_accepted++;
            compute_fill_rect('{mode: req_tuser, frame_top: req_tdata[49:40],
                                palette_color: req_tdata[39:24],
                                pixel_index: req_tdata[23:16], row: req_tdata[15:8],
                                column: req_tdata[7:0]});
         end
         if (rsp_tvalid && rsp_tready) begin
            rects_received++;
            check_fill_rect(fill_rect_type'(rsp_tdata[58:0]));
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      scr_w = int'(SCREEN_RESET);
      scr_h = int'(SCREEN_RESET);
      img_w = int'(IMAGE_RESET);
      img_h = int'(IMAGE_RESET);
      frame_cancelled = 1'b0;
      gen_cancelled = 1'b0;
      clear_canvas();
      for (int i = 0; i < 256; i++) begin
         palette_shadow[i] = '0;
         palette_seen[i] = 1'b0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed opening under the reset sizes
      queue_item(MODE_PALETTE, 0, 0, 0, 16'h0000, 0);
      queue_item(MODE_PALETTE, 255, 255, 255, 16'hFFFF, 1023);
      queue_item(MODE_PALETTE, 0, 0, 1, CANVAS_CLEAR, 0);
      queue_item(MODE_PALETTE, 0, 0, 2, 16'hA5A5, 0);
      queue_item(MODE_PALETTE, 0, 0, 3, 16'h5A5A, 0);
      queue_item(MODE_PIXEL, 0, 0, 1, 0, 0);        // same as cleared canvas
      queue_item(MODE_PIXEL, 0, 0, 255, 0, 0);
      queue_item(MODE_PIXEL, 0, 0, 255, 0, 0);      // unchanged
      queue_item(MODE_PIXEL, 239, 239, 0, 16'hFFFF, 1023);
      queue_item(MODE_PIXEL, 240, 0, 2, 0, 0);      // outside image
      queue_item(MODE_PIXEL, 0, 240, 2, 0, 0);
      queue_item(MODE_PIXEL, 255, 255, 3, 0, 0);
      queue_item(MODE_UNUSED, 17, 34, 3, 16'h1234, 77);
      queue_item(MODE_CANCEL, 0, 0, 0, 0, 0);
      queue_item(MODE_PIXEL, 5, 5, 2, 0, 0);        // dropped while cancelled
      queue_item(MODE_PALETTE, 0, 0, 4, 16'h0F0F, 0);
      queue_item(MODE_PIXEL, 239, 239, 2, 0, 0);    // last pixel ends the cancel
      queue_item(MODE_PIXEL, 5, 5, 4, 0, 300);
      queue_item(MODE_PALETTE, 0, 0, 128, 16'h8001, 0);
      queue_item(MODE_PIXEL, 128, 127, 128, 0, 512);
      queue_item(MODE_PIXEL, 1, 2, 3, 16'hFFFF, 1);
      queue_random(450, 1'b1);
      wait_idle();

      run_setting(1024, 1024, 256, 256, 1'b1, 300, 1'b1);
      // screen change alone keeps the canvas cache
      run_setting(173, 911, 256, 256, 1'b0, 250, 1'b1);
      run_setting(1, 1, 1, 1, 1'b1, 250, 1'b1);
      run_setting(1000, 37, 7, 13, 1'b1, 300, 1'b1);
      // sizes beyond the usual range wrap the coordinates
      run_setting(2047, 2047, 300, 511, 1'b1, 200, 1'b0);

      mismatch_count += fill_rects_due.size();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
